// File: hw/rtl/itm_tla_pkg.sv
// Package for the ITM trace line assembler: widths, header and character
// codes, register indexes and reset values.
// Depends on nothing; every other file of the block refers to it.
`default_nettype none

package itm_tla_pkg;

   // Field and state widths.
   localparam int TIME_BITS       = 48;
   localparam int TIME_FIELD_BITS = 48;
   localparam int HDR_BITS        = 8;
   localparam int CHAR_BITS       = 8;
   localparam int CHAN_BITS       = 5;
   localparam int LEN_BITS        = 9;
   localparam int MASK_BITS       = 32;
   localparam int GAP_BITS        = 24;
   localparam int CSR_IDX_BITS    = 2;
   localparam int CSR_DATA_BITS   = 32;

   typedef logic [TIME_BITS-1:0]       time_type;
   typedef logic [TIME_FIELD_BITS-1:0] time_field_type;

   // Header codes: the low three bits mark a stimulus packet.
   localparam logic [2:0] HDR_STIMULUS = 3'b001;

   // Line terminators.
   localparam logic [CHAR_BITS-1:0] CHAR_CR = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CHAR_LF = 8'h0A;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_CHANNEL_ENABLE_MASK = 2'd0,
      CSR_MAX_LINE_LENGTH     = 2'd1,
      CSR_GAP_LIMIT_US        = 2'd2
   } csr_index_type;

   // Register reset values.
   localparam logic [MASK_BITS-1:0] RST_CHANNEL_ENABLE_MASK = 32'hFFFF_FFFF;
   localparam logic [LEN_BITS-1:0]  RST_MAX_LINE_LENGTH     = 9'd256;
   localparam logic [GAP_BITS-1:0]  RST_GAP_LIMIT_US        = 24'd100000;

endpackage

`default_nettype wire

// File: hw/rtl/itm_tla_req_if.sv
// Input channel of the ITM trace line assembler: one header/payload word.
// Depends on itm_tla_pkg for the field widths.
`default_nettype none

interface itm_tla_req_if;
   logic                               valid;
   logic                               ready;
   logic [itm_tla_pkg::HDR_BITS-1:0]   header;
   logic [itm_tla_pkg::CHAR_BITS-1:0]  payload;
   itm_tla_pkg::time_field_type        time_us;
   logic                               packet_last;

   modport source (output valid, header, payload, time_us, packet_last, input ready);
   modport sink   (input valid, header, payload, time_us, packet_last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/itm_tla_rsp_if.sv
// Result channel of the ITM trace line assembler: one line character word.
// Depends on itm_tla_pkg for the field widths.
`default_nettype none

interface itm_tla_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [itm_tla_pkg::CHAN_BITS-1:0]  channel;
   logic [itm_tla_pkg::CHAR_BITS-1:0]  character;
   logic                               starts_line;
   itm_tla_pkg::time_field_type        rel_time_us;

   modport source (output valid, channel, character, starts_line, rel_time_us, input ready);
   modport sink   (input valid, channel, character, starts_line, rel_time_us, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/itm_tla_csr_if.sv
// Configuration write channel of the ITM trace line assembler.
// Depends on itm_tla_pkg for the index and data widths.
`default_nettype none

interface itm_tla_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [itm_tla_pkg::CSR_IDX_BITS-1:0]   index;
   logic [itm_tla_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/itm_trace_line_assembler.sv
// Top level of the ITM trace line assembler.
// Depends on itm_tla_pkg and the interfaces itm_tla_req_if, itm_tla_rsp_if
// and itm_tla_csr_if.
//
// Usage:
// - req_chan takes one ITM header/payload word with its capture time in
//   microseconds. Words that are not stimulus packets, or whose channel is
//   disabled, and CR/LF characters produce no result.
// - rsp_chan gives each stored character with its channel, a start-of-line
//   flag and the line start time relative to the first line.
// - csr_chan writes the channel enable mask, the maximum line length and the
//   gap limit; it is always ready and should be used only while idle.
// - A word accepted on req_chan is held in the input register, evaluated
//   against the line state, and its result is loaded into the result
//   register that drives rsp_chan. One word is accepted every cycle
//   unless rsp_chan stalls.
// - When rsp_chan stalls, the result register holds; one more word can wait
//   in the input register, then req_chan.ready drops.
// - Synchronous reset restores the register reset values and forgets any
//   open line; no clearing pass is needed.
`default_nettype none

module itm_trace_line_assembler (
   input  wire               clock,
   input  wire               reset,
   itm_tla_req_if.sink       req_chan,
   itm_tla_rsp_if.source     rsp_chan,
   itm_tla_csr_if.sink       csr_chan
);

   localparam int TB = itm_tla_pkg::TIME_BITS;

   // Configuration registers.
   logic [itm_tla_pkg::MASK_BITS-1:0] chan_mask_ff, chan_mask_in;
   logic [itm_tla_pkg::LEN_BITS-1:0]  max_len_ff, max_len_in;
   logic [itm_tla_pkg::GAP_BITS-1:0]  gap_limit_ff, gap_limit_in;

   // Input register.
   logic                               s1_valid_ff, s1_valid_in;
   logic [itm_tla_pkg::HDR_BITS-1:0]   s1_header_ff, s1_header_in;
   logic [itm_tla_pkg::CHAR_BITS-1:0]  s1_payload_ff, s1_payload_in;
   itm_tla_pkg::time_type              s1_time_ff, s1_time_in;

   // Line state.
   logic                               line_open_ff, line_open_in;
   logic                               line_closed_ff, line_closed_in;
   logic [itm_tla_pkg::CHAN_BITS-1:0]  line_chan_ff, line_chan_in;
   logic [itm_tla_pkg::LEN_BITS-1:0]   line_len_ff, line_len_in;
   itm_tla_pkg::time_type              line_start_ff, line_start_in;
   itm_tla_pkg::time_type              first_time_ff, first_time_in;
   itm_tla_pkg::time_type              line_rel_ff, line_rel_in;

   // Result register.
   logic                               out_valid_ff, out_valid_in;
   logic [itm_tla_pkg::CHAN_BITS-1:0]  out_chan_ff, out_chan_in;
   logic [itm_tla_pkg::CHAR_BITS-1:0]  out_char_ff, out_char_in;
   logic                               out_start_ff, out_start_in;
   itm_tla_pkg::time_type              out_rel_ff, out_rel_in;

   // Handshake and evaluation signals.
   logic                               advance;
   logic                               req_fire;
   logic                               process;
   logic [itm_tla_pkg::CHAN_BITS-1:0]  chan;
   logic                               take;
   logic                               is_newline;
   logic [TB:0]                        gap_diff;
   logic                               gap_exceeded;
   logic [TB:0]                        first_diff;
   itm_tla_pkg::time_type              new_rel;
   logic                               line_ends;
   logic [63:0]                        time_wide;
   logic [63:0]                        rel_wide;

   // The pipeline moves unless a result waits for a stalled receiver.
   assign advance  = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign process  = s1_valid_ff && advance;
   assign csr_chan.ready = 1'b1;

   // Input time is reduced to the internal time width.
   assign time_wide = 64'(req_chan.time_us);

   // Packet decode and line end tests.
   assign chan       = s1_header_ff[7:3];
   assign take       = process && (s1_header_ff[2:0] == itm_tla_pkg::HDR_STIMULUS)
                       && chan_mask_ff[chan];
   assign is_newline = (s1_payload_ff == itm_tla_pkg::CHAR_CR)
                       || (s1_payload_ff == itm_tla_pkg::CHAR_LF);

   // A borrow means the word is older than the line start: no gap then.
   assign gap_diff     = {1'b0, s1_time_ff} - {1'b0, line_start_ff};
   assign gap_exceeded = !gap_diff[TB] && (gap_diff[TB-1:0] > TB'(gap_limit_ff));
   assign line_ends    = line_closed_ff || (line_chan_ff != chan)
                         || (line_len_ff >= max_len_ff) || gap_exceeded;

   // Start time of a new line relative to the first line, clamped at zero.
   assign first_diff = {1'b0, s1_time_ff} - {1'b0, first_time_ff};
   assign new_rel    = first_diff[TB] ? '0 : first_diff[TB-1:0];

   assign rel_wide = 64'(out_rel_ff);

   // Configuration writes.
   always_comb begin
      chan_mask_in = chan_mask_ff;
      max_len_in   = max_len_ff;
      gap_limit_in = gap_limit_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            itm_tla_pkg::CSR_CHANNEL_ENABLE_MASK: begin
               chan_mask_in = csr_chan.data;
            end
            itm_tla_pkg::CSR_MAX_LINE_LENGTH: begin
               max_len_in = csr_chan.data[itm_tla_pkg::LEN_BITS-1:0];
            end
            itm_tla_pkg::CSR_GAP_LIMIT_US: begin
               gap_limit_in = csr_chan.data[itm_tla_pkg::GAP_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Input register loads whenever a word is accepted.
   always_comb begin
      s1_header_in  = s1_header_ff;
      s1_payload_in = s1_payload_ff;
      s1_time_in    = s1_time_ff;
      if (req_fire) begin
         s1_valid_in   = 1'b1;
         s1_header_in  = req_chan.header;
         s1_payload_in = req_chan.payload;
         s1_time_in    = time_wide[TB-1:0];
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // Line state update and result formation.
   always_comb begin
      line_open_in   = line_open_ff;
      line_closed_in = line_closed_ff;
      line_chan_in   = line_chan_ff;
      line_len_in    = line_len_ff;
      line_start_in  = line_start_ff;
      first_time_in  = first_time_ff;
      line_rel_in    = line_rel_ff;
      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      out_chan_in    = out_chan_ff;
      out_char_in    = out_char_ff;
      out_start_in   = out_start_ff;
      out_rel_in     = out_rel_ff;
      if (take) begin
         priority if (line_open_ff && is_newline) begin
            // Terminator closes the open line without a result.
            line_closed_in = 1'b1;
         end else if (line_open_ff && !line_ends) begin
            // Character joins the open line.
            line_len_in  = line_len_ff + 1'b1;
            out_valid_in = 1'b1;
            out_chan_in  = line_chan_ff;
            out_char_in  = s1_payload_ff;
            out_start_in = 1'b0;
            out_rel_in   = line_rel_ff;
         end else if (!line_open_ff && is_newline) begin
            // Terminator before any line: nothing to do.
         end else begin
            // Character opens a new line; the very first one sets the origin.
            if (!line_open_ff) begin
               first_time_in = s1_time_ff;
               line_rel_in   = '0;
               out_rel_in    = '0;
            end else begin
               line_rel_in = new_rel;
               out_rel_in  = new_rel;
            end
            line_open_in   = 1'b1;
            line_closed_in = 1'b0;
            line_chan_in   = chan;
            line_len_in    = itm_tla_pkg::LEN_BITS'(1);
            line_start_in  = s1_time_ff;
            out_valid_in   = 1'b1;
            out_chan_in    = chan;
            out_char_in    = s1_payload_ff;
            out_start_in   = 1'b1;
         end
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_mask_ff   <= itm_tla_pkg::RST_CHANNEL_ENABLE_MASK;
         max_len_ff     <= itm_tla_pkg::RST_MAX_LINE_LENGTH;
         gap_limit_ff   <= itm_tla_pkg::RST_GAP_LIMIT_US;
         s1_valid_ff    <= 1'b0;
         line_open_ff   <= 1'b0;
         line_closed_ff <= 1'b0;
         line_chan_ff   <= '0;
         line_len_ff    <= '0;
         line_start_ff  <= '0;
         first_time_ff  <= '0;
         line_rel_ff    <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         chan_mask_ff   <= chan_mask_in;
         max_len_ff     <= max_len_in;
         gap_limit_ff   <= gap_limit_in;
         s1_valid_ff    <= s1_valid_in;
         line_open_ff   <= line_open_in;
         line_closed_ff <= line_closed_in;
         line_chan_ff   <= line_chan_in;
         line_len_ff    <= line_len_in;
         line_start_ff  <= line_start_in;
         first_time_ff  <= first_time_in;
         line_rel_ff    <= line_rel_in;
         out_valid_ff   <= out_valid_in;
      end
      s1_header_ff  <= s1_header_in;
      s1_payload_ff <= s1_payload_in;
      s1_time_ff    <= s1_time_in;
      out_chan_ff   <= out_chan_in;
      out_char_ff   <= out_char_in;
      out_start_ff  <= out_start_in;
      out_rel_ff    <= out_rel_in;
   end

   // Result channel.
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.channel     = out_chan_ff;
   assign rsp_chan.character   = out_char_ff;
   assign rsp_chan.starts_line = out_start_ff;
   assign rsp_chan.rel_time_us = rel_wide[itm_tla_pkg::TIME_FIELD_BITS-1:0];

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the ITM trace line assembler.
// Directed table, then randomized trace streams checked against a line model.
// Depends on itm_tla_pkg, the three channel interfaces and the top level.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import itm_tla_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 5;
   localparam int LONG_HOLD_AT  = 120;
   localparam int LONG_HOLD_LEN = 80;
   localparam int DIRECTED_ROWS = 23;

   // Header type codes that are not stimulus packets.
   localparam logic [2:0] HDR_NONSTIM_000 = 3'b000;
   localparam logic [2:0] HDR_NONSTIM_010 = 3'b010;
   localparam logic [2:0] HDR_NONSTIM_011 = 3'b011;
   localparam logic [2:0] HDR_NONSTIM_110 = 3'b110;
   localparam logic [2:0] HDR_NONSTIM_111 = 3'b111;

   // Register index past the end of the register list.
   localparam logic [CSR_IDX_BITS-1:0] CSR_INDEX_SPARE = 2'd3;

   typedef struct packed {
      logic [CHAN_BITS-1:0] channel;
      logic [CHAR_BITS-1:0] character;
      logic                 starts_line;
      time_field_type       rel_time_us;
   } line_char_t;

   typedef struct packed {
      logic [HDR_BITS-1:0]  header;
      logic [CHAR_BITS-1:0] payload;
      time_type             time_us;
      logic                 last;
      logic                 typed;
      logic                 has_result;
      logic [CHAN_BITS-1:0] exp_channel;
      logic [CHAR_BITS-1:0] exp_character;
      logic                 exp_starts;
      time_field_type       exp_rel;
   } directed_row_t;

   logic clock = 1'b0;
   logic reset;

   itm_tla_req_if req_chan ();
   itm_tla_rsp_if rsp_chan ();
   itm_tla_csr_if csr_chan ();

   itm_trace_line_assembler u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #5 clock = ~clock;

   // Shadow copy of the registers.
   logic [MASK_BITS-1:0] enable_mask = RST_CHANNEL_ENABLE_MASK;
   logic [LEN_BITS-1:0]  max_len     = RST_MAX_LINE_LENGTH;
   logic [GAP_BITS-1:0]  gap_limit   = RST_GAP_LIMIT_US;

   // Shadow copy of the line state.
   bit                   line_is_open   = 1'b0;
   bit                   line_is_closed = 1'b0;
   logic [CHAN_BITS-1:0] line_chan      = '0;
   logic [LEN_BITS-1:0]  line_len       = '0;
   time_type             line_start_us  = '0;
   time_type             first_line_us  = '0;

   line_char_t expected_chars [$];
   int         fail_count     = 0;
   int         words_accepted = 0;
   int         cycle_count    = 0;
   bit         sender_idle_on   = 1'b1;
   bit         receiver_idle_on = 1'b1;
   time_type   stream_time      = '0;

   directed_row_t stim_table [DIRECTED_ROWS];

   // Line assembly for one accepted word; returns 1 when a character is emitted.
   function automatic bit predict_line_char(input logic [HDR_BITS-1:0] hdr,
                                            input logic [CHAR_BITS-1:0] pay,
                                            input time_type now,
                                            output line_char_t res);
      logic [CHAN_BITS-1:0] chan;
      bit                   is_newline;
      res  = '0;
      chan = hdr[7:3];
      if (hdr[2:0] != HDR_STIMULUS) return 1'b0;
      if (!enable_mask[chan]) return 1'b0;
      is_newline = (pay == CHAR_CR) || (pay == CHAR_LF);

      // An open line closes on a terminator, channel change, length or gap.
      if (line_is_open) begin
         if (is_newline) begin
            line_is_closed = 1'b1;
            return 1'b0;
         end
         if (line_chan != chan)
            line_is_closed = 1'b1;
         else if (line_len >= max_len)
            line_is_closed = 1'b1;
         if (now > line_start_us && (now - line_start_us) > {24'd0, gap_limit})
            line_is_closed = 1'b1;
      end

      // The character joins the current line.
      if (line_is_open && !line_is_closed) begin
         line_len        = line_len + 1'b1;
         res.channel     = line_chan;
         res.character   = pay;
         res.starts_line = 1'b0;
         res.rel_time_us = (line_start_us > first_line_us) ?
                           line_start_us - first_line_us : '0;
         return 1'b1;
      end
      if (!line_is_open && is_newline) return 1'b0;

      // The character opens a new line.
      if (!line_is_open) begin
         first_line_us   = now;
         res.rel_time_us = '0;
      end else begin
         res.rel_time_us = (now > first_line_us) ? now - first_line_us : '0;
      end
      line_is_open    = 1'b1;
      line_is_closed  = 1'b0;
      line_chan       = chan;
      line_len        = 9'd1;
      line_start_us   = now;
      res.channel     = chan;
      res.character   = pay;
      res.starts_line = 1'b1;
      return 1'b1;
   endfunction

   function automatic logic [CHAN_BITS-1:0] pick_enabled_channel();
      logic [CHAN_BITS-1:0] c;
      c = 5'($urandom_range(0, 31));
      if (enable_mask != '0) begin
         while (!enable_mask[c]) c = 5'($urandom_range(0, 31));
      end
      return c;
   endfunction

   // Offer one input word, wait for its acceptance and predict its outcome.
   task automatic send_word(input logic [HDR_BITS-1:0] hdr, input logic [CHAR_BITS-1:0] pay,
                            input time_type stamp, input logic last,
                            output bit has_char, output line_char_t predicted);
      int gap;
      gap = (sender_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.header      <= hdr;
      req_chan.payload     <= pay;
      req_chan.time_us     <= stamp;
      req_chan.packet_last <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      words_accepted++;
      has_char = predict_line_char(hdr, pay, stamp, predicted);
   endtask

   // Stop sending and wait until every expected character has come out.
   task automatic drain_block();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      case (idx)
         CSR_CHANNEL_ENABLE_MASK: enable_mask = value;
         CSR_MAX_LINE_LENGTH:     max_len     = value[LEN_BITS-1:0];
         CSR_GAP_LIMIT_US:        gap_limit   = value[GAP_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic start_phase(input logic [31:0] mask, input logic [31:0] len_value,
                              input logic [31:0] gap_value);
      drain_block();
      write_reg(CSR_CHANNEL_ENABLE_MASK, mask);
      write_reg(CSR_MAX_LINE_LENGTH, len_value);
      write_reg(CSR_GAP_LIMIT_US, gap_value);
   endtask

   // Random trace stream: mostly stimulus text on a sticky channel, some noise.
   task automatic run_random_phase(input int n_items, input int nl_pct, input int switch_pct,
                                   input int noise_pct, input int step_max, input int drain_at);
      logic [HDR_BITS-1:0]  hdr;
      logic [CHAR_BITS-1:0] pay;
      logic [CHAN_BITS-1:0] chan;
      int                   roll;
      bit                   has_char;
      line_char_t           predicted;
      chan = pick_enabled_channel();
      for (int i = 0; i < n_items; i++) begin
         if (i == drain_at) drain_block();
         if ($urandom_range(0, 99) < noise_pct) begin
            hdr = 8'($urandom_range(0, 255));
            pay = 8'($urandom_range(0, 255));
         end else begin
            if ($urandom_range(0, 99) < switch_pct) chan = pick_enabled_channel();
            hdr = {chan, HDR_STIMULUS};
            if ($urandom_range(0, 99) < nl_pct)
               pay = $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
            else if ($urandom_range(0, 3) == 0)
               pay = 8'($urandom_range(0, 255));
            else
               pay = 8'($urandom_range(32, 126));
         end

         // Time mostly advances; sometimes it steps back or lands on the gap edge.
         roll = $urandom_range(0, 99);
         if (roll < 3)
            stream_time = stream_time - 48'($urandom_range(1, 5000));
         else if (roll < 8)
            stream_time = line_start_us + {24'd0, gap_limit} + 48'($urandom_range(0, 1));
         else
            stream_time = stream_time + 48'($urandom_range(0, step_max));

         send_word(hdr, pay, stream_time, 1'($urandom_range(0, 1)), has_char, predicted);
         if (has_char) expected_chars.push_back(predicted);
      end
   endtask

   // Receiver ready: random short stalls, plus one long hold-off.
   int stall_left     = 0;
   bit long_hold_done = 1'b0;

   always @(negedge clock) begin
      if (!long_hold_done && words_accepted >= LONG_HOLD_AT) begin
         long_hold_done = 1'b1;
         stall_left     = LONG_HOLD_LEN;
      end else if (stall_left == 0 && receiver_idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Compare each result word with the oldest expected character.
   always @(posedge clock) begin : check_results
      line_char_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_chars.size() == 0) begin
            $error("result word with nothing expected: channel %0d, character %0h",
                   rsp_chan.channel, rsp_chan.character);
            fail_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_chan.channel !== want.channel) begin
               $error("channel: expected %0d, actual %0d", want.channel, rsp_chan.channel);
               fail_count++;
            end
            if (rsp_chan.character !== want.character) begin
               $error("character: expected %0h, actual %0h",
                      want.character, rsp_chan.character);
               fail_count++;
            end
            if (rsp_chan.starts_line !== want.starts_line) begin
               $error("starts_line: expected %0b, actual %0b",
                      want.starts_line, rsp_chan.starts_line);
               fail_count++;
            end
            if (rsp_chan.rel_time_us !== want.rel_time_us) begin
               $error("rel_time_us: expected %0h, actual %0h",
                      want.rel_time_us, rsp_chan.rel_time_us);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on the total run length.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("itm_trace_line_assembler test failed");
      $finish;
   end

   initial begin : stimulus
      bit         has_char;
      line_char_t predicted;
      line_char_t typed_char;

      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.header      = '0;
      req_chan.payload     = '0;
      req_chan.time_us     = '0;
      req_chan.packet_last = 1'b0;
      rsp_chan.ready       = 1'b0;
      csr_chan.valid       = 1'b0;
      csr_chan.index       = CSR_CHANNEL_ENABLE_MASK;
      csr_chan.data        = '0;

      // Directed words at the reset settings. Typed rows give the result outright.
      stim_table = '{
         // Not stimulus packets.
         '{{5'd0, HDR_NONSTIM_000}, 8'h41, 48'd0, 1'b0, 1'b1, 1'b0, 5'd0, 8'h00, 1'b0, 48'd0},
         '{{5'd0, HDR_NONSTIM_111}, 8'h41, 48'd0, 1'b0, 1'b1, 1'b0, 5'd0, 8'h00, 1'b0, 48'd0},
         // Terminators before any line exists.
         '{{5'd0, HDR_STIMULUS}, CHAR_CR, 48'd10, 1'b0, 1'b1, 1'b0, 5'd0, 8'h00, 1'b0, 48'd0},
         '{{5'd0, HDR_STIMULUS}, CHAR_LF, 48'd10, 1'b1, 1'b1, 1'b0, 5'd0, 8'h00, 1'b0, 48'd0},
         // First line, then a second character on it.
         '{{5'd0, HDR_STIMULUS}, 8'h41, 48'd1000, 1'b0, 1'b1, 1'b1, 5'd0, 8'h41, 1'b1, 48'd0},
         '{{5'd0, HDR_STIMULUS}, 8'h42, 48'd1500, 1'b1, 1'b1, 1'b1, 5'd0, 8'h42, 1'b0, 48'd0},
         // Channel change opens a line on the top channel.
         '{{5'd31, HDR_STIMULUS}, 8'hFF, 48'd2000, 1'b0,
           1'b1, 1'b1, 5'd31, 8'hFF, 1'b1, 48'd1000},
         // Terminator closes the line without a result.
         '{{5'd31, HDR_STIMULUS}, CHAR_LF, 48'd2100, 1'b0,
           1'b1, 1'b0, 5'd0, 8'h00, 1'b0, 48'd0},
         '{{5'd31, HDR_STIMULUS}, 8'h00, 48'd3000, 1'b0,
           1'b1, 1'b1, 5'd31, 8'h00, 1'b1, 48'd2000},
         // Exactly at the gap limit the line stays open; one past it a new one starts.
         '{{5'd31, HDR_STIMULUS}, 8'h78, 48'd103000, 1'b0,
           1'b1, 1'b1, 5'd31, 8'h78, 1'b0, 48'd2000},
         '{{5'd31, HDR_STIMULUS}, 8'h79, 48'd103001, 1'b0,
           1'b1, 1'b1, 5'd31, 8'h79, 1'b1, 48'd102001},
         // Time earlier than the line start does not break the line.
         '{{5'd31, HDR_STIMULUS}, 8'h7A, 48'd500, 1'b1,
           1'b1, 1'b1, 5'd31, 8'h7A, 1'b0, 48'd102001},
         '{{5'd0, HDR_NONSTIM_010}, CHAR_CR, 48'd600, 1'b0,
           1'b1, 1'b0, 5'd0, 8'h00, 1'b0, 48'd0},
         '{{5'd31, HDR_NONSTIM_110}, 8'h7F, 48'hFFFF_FFFF_FFFF, 1'b0,
           1'b1, 1'b0, 5'd0, 8'h00, 1'b0, 48'd0},
         // Largest time stamp, then time zero on the same line.
         '{{5'd1, HDR_STIMULUS}, 8'h71, 48'hFFFF_FFFF_FFFF, 1'b0,
           1'b1, 1'b1, 5'd1, 8'h71, 1'b1, 48'hFFFF_FFFF_FC17},
         '{{5'd1, HDR_STIMULUS}, 8'h72, 48'd0, 1'b0,
           1'b1, 1'b1, 5'd1, 8'h72, 1'b0, 48'hFFFF_FFFF_FC17},
         // Line start before the first line gives a relative time of zero.
         '{{5'd2, HDR_STIMULUS}, 8'h31, 48'd0, 1'b0, 1'b1, 1'b1, 5'd2, 8'h31, 1'b1, 48'd0},
         '{{5'd2, HDR_STIMULUS}, 8'h32, 48'd5, 1'b1, 1'b1, 1'b1, 5'd2, 8'h32, 1'b0, 48'd0},
         // Rows left to the line model.
         '{{5'd2, HDR_STIMULUS}, 8'h80, 48'd6, 1'b0, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0, 48'd0},
         '{{5'd3, HDR_STIMULUS}, CHAR_CR, 48'd7, 1'b0, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0, 48'd0},
         '{{5'd3, HDR_STIMULUS}, 8'h55, 48'd8, 1'b0, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0, 48'd0},
         '{{5'd21, HDR_NONSTIM_011}, 8'hAA, 48'd9, 1'b1, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0, 48'd0},
         '{{5'd0, HDR_STIMULUS}, 8'h20, 48'd200000, 1'b0,
           1'b0, 1'b0, 5'd0, 8'h00, 1'b0, 48'd0}
      };

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[r]) begin
         send_word(stim_table[r].header, stim_table[r].payload, stim_table[r].time_us,
                   stim_table[r].last, has_char, predicted);
         if (stim_table[r].typed) begin
            if (stim_table[r].has_result) begin
               typed_char = '{stim_table[r].exp_channel, stim_table[r].exp_character,
                              stim_table[r].exp_starts, stim_table[r].exp_rel};
               expected_chars.push_back(typed_char);
            end
         end else if (has_char) begin
            expected_chars.push_back(predicted);
         end
      end

      // Reset settings; the long receiver hold-off and a sender pause land here.
      stream_time = 48'd200000;
      run_random_phase(250, 5, 5, 10, 2000, 180);

      // One channel, one-character lines, zero gap, upper length bits ignored.
      start_phase(32'h0000_0001, 32'hFFFF_FE01, 32'h0000_0000);
      stream_time = time_type'({$urandom(), $urandom()});
      run_random_phase(150, 5, 0, 10, 3, -1);

      // Longest lines and largest gap; the sender never idles here.
      sender_idle_on = 1'b0;
      start_phase($urandom() | 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      stream_time = time_type'({$urandom(), $urandom()});
      run_random_phase(600, 0, 0, 2, 100, -1);
      sender_idle_on = 1'b1;

      // Every channel disabled; the spare register index must have no effect.
      start_phase(32'h0000_0000, 32'd256, 32'd100000);
      write_reg(CSR_INDEX_SPARE, $urandom());
      run_random_phase(40, 5, 20, 10, 2000, -1);

      // Length zero: every character opens a line.
      start_phase($urandom(), 32'h0000_0200, $urandom_range(0, 5000));
      write_reg(CSR_INDEX_SPARE, $urandom());
      run_random_phase(150, 5, 10, 10, 200, -1);

      // Random settings, frequent channel changes and noise.
      start_phase($urandom() | 32'h8000_0000, $urandom_range(1, 256), $urandom());
      stream_time = time_type'({$urandom(), $urandom()});
      run_random_phase(250, 8, 20, 20, 100000, -1);

      // Back to reset values, no idling on either side.
      start_phase(32'hFFFF_FFFF, 32'd256, 32'd100000);
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      run_random_phase(250, 5, 5, 5, 2000, -1);

      drain_block();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("itm_trace_line_assembler test passed");
      else
         $display("itm_trace_line_assembler test failed");
      $finish;
   end

endmodule

`default_nettype wire
